// ===== rtl/slu_pkg.sv =====
// Shared types and constants of the shuffled Lehmer uniform generator.
// No dependencies; imported by every module of the block but slu_ram.
package slu_pkg;

	localparam int TABLE_SIZE  = 32;
	localparam int IDX_W       = $clog2(TABLE_SIZE);
	localparam int CNT_W       = $clog2(TABLE_SIZE + 1);
	localparam int WORD_W      = 31;
	localparam int MULTIPLIER  = 16807;
	localparam int MULT_W      = $clog2(MULTIPLIER + 1);
	localparam int PROD_W      = WORD_W + MULT_W;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;

	// modulus is the Mersenne prime 2^WORD_W - 1, reduced by folding
	localparam logic [WORD_W-1:0] MODULUS = {WORD_W{1'b1}};

	typedef struct packed {
		logic              load;
		logic              step;
		logic [WORD_W-1:0] seed;
	} lcg_ctl_t;

endpackage

// ===== rtl/slu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module slu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/slu_lehmer.sv =====
// Lehmer core: x <- MULTIPLIER * x mod (2^31 - 1); the product is registered, then folded back into x.
// Depends on slu_pkg.
module slu_lehmer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slu_pkg::lcg_ctl_t             ctl,
	output logic [slu_pkg::WORD_W-1:0]    x
);
	import slu_pkg::*;

	logic [WORD_W-1:0] x_q;
	logic [PROD_W-1:0] prod_s1;
	logic              vld_s1;
	logic [WORD_W:0]   fold;
	logic [WORD_W-1:0] red;

	// fold high part onto low part; sum stays below twice the modulus
	always_comb begin
		fold = {1'b0, prod_s1[WORD_W-1:0]} + (WORD_W+1)'(prod_s1[PROD_W-1:WORD_W]);
		if (fold >= {1'b0, MODULUS}) begin
			red = WORD_W'(fold - {1'b0, MODULUS});
		end else begin
			red = fold[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= WORD_W'(1);
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.step;
			if (ctl.load) begin
				x_q <= ctl.seed;
			end else if (vld_s1) begin
				x_q <= red;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(x_q) * PROD_W'(MULTIPLIER);
	end

	assign x = x_q;

endmodule

// ===== rtl/shuffled_lehmer_uniform_rng_top.sv =====
// Shuffled Lehmer uniform generator, top level.
// Depends on slu_pkg, slu_ram and slu_lehmer.
//
// Usage:
//   s_tvalid/s_tready/s_tdata: request channel; bit 0 set asks for a deviate,
//     a transaction with bit 0 clear is taken and dropped.
//   m_tvalid/m_tready/m_tdata: result channel, one 31-bit deviate per request.
//   cfg_valid/cfg_ready/cfg_data: seed write; write only while idle.
//   The first request after reset or a seed write primes the 32-entry table:
//     33 Lehmer steps, 32 to fill the table and one for the held value; the
//     draw of that request then runs as on a primed table.
//   Primed: a request passes ST_READ, which fills the pending slot, then
//     m_tvalid is set; a new request can be taken in ST_WRITE, a rate set by
//     the table read plus write-back and the multiply-and-fold loop of the core.
//   A finished result sits in a pending slot while m_tvalid is stalled;
//   s_tready is low during a draw or priming and while that slot cannot drain.
//   Reset: seed 1, table unprimed, no result pending.
module shuffled_lehmer_uniform_rng_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [slu_pkg::IN_TDATA_W-1:0]    s_tdata,   // [0] draw_request
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [slu_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [30:0] uniform_deviate
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [slu_pkg::WORD_W-1:0]        cfg_data   // seed_value
);
	import slu_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_ISSUE   = 3'd1;
	localparam logic [2:0] ST_READ    = 3'd2;
	localparam logic [2:0] ST_WRITE   = 3'd3;
	localparam logic [2:0] ST_P_WAIT  = 3'd4;
	localparam logic [2:0] ST_P_STORE = 3'd5;

	logic [2:0]        state_q;
	logic              primed_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_q;
	logic              m_tvalid_q;
	logic [WORD_W-1:0] m_data_q;
	logic [WORD_W-1:0] y_q;
	logic [IDX_W-1:0]  idx_q;
	logic              fwd_q;
	logic [WORD_W-1:0] fwd_data_q;

	logic              out_free;
	logic              acc;
	logic              req;
	logic              issue;
	logic              prime_go;
	logic              prime_done;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [IDX_W-1:0]  ram_raddr;
	logic [WORD_W-1:0] ram_rdata;
	logic [WORD_W-1:0] x;
	lcg_ctl_t          lcg_ctl;

	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE || state_q == ST_WRITE) && (!pend_q || out_free);
	assign acc       = s_tvalid && s_tready;
	assign req       = acc && s_tdata[0];
	assign issue     = (req && primed_q) || (state_q == ST_ISSUE);
	assign prime_go  = req && !primed_q;
	assign prime_done = (cnt_q == CNT_W'(TABLE_SIZE));
	assign ram_raddr = y_q[IDX_W-1:0];
	assign ram_we    = (state_q == ST_WRITE) || (state_q == ST_P_STORE && !prime_done);
	assign ram_waddr = (state_q == ST_WRITE) ? idx_q : cnt_q[IDX_W-1:0];

	always_comb begin
		lcg_ctl.load = cfg_valid && cfg_ready;
		lcg_ctl.seed = cfg_data;
		lcg_ctl.step = issue || prime_go || (state_q == ST_P_STORE && !prime_done);
	end

	slu_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(x),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	slu_lehmer u_lehmer (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (lcg_ctl),
		.x     (x)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			primed_q   <= 1'b0;
			cnt_q      <= '0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			y_q        <= '0;
			fwd_q      <= 1'b0;
		end else begin
			if (pend_q && out_free) begin
				m_tvalid_q <= 1'b1;
				pend_q     <= 1'b0;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (issue) begin
				fwd_q <= (state_q == ST_WRITE) && (ram_raddr == idx_q);
			end
			case (state_q)
				ST_IDLE, ST_WRITE: begin
					if (prime_go) begin
						cnt_q   <= '0;
						state_q <= ST_P_WAIT;
					end else if (issue) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					y_q     <= fwd_q ? fwd_data_q : ram_rdata;
					pend_q  <= 1'b1;
					state_q <= ST_WRITE;
				end
				ST_P_WAIT: begin
					state_q <= ST_P_STORE;
				end
				ST_P_STORE: begin
					if (prime_done) begin
						y_q      <= x;
						primed_q <= 1'b1;
						state_q  <= ST_ISSUE;
					end else begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= ST_P_WAIT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_valid && cfg_ready) begin
				primed_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_q      <= ram_raddr;
			fwd_data_q <= x;
		end
		if (pend_q && out_free) begin
			m_data_q <= y_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'(m_data_q);

	// a new result never lands on an undrained one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_READ && pend_q))
		else $error("result slot overwritten");

	// a table lookup is only issued once the table is primed
	a_issue_primed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> primed_q)
		else $error("lookup before priming");

	// priming never runs past the table plus the held value
	a_prime_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P_STORE || state_q == ST_P_WAIT) |-> (cnt_q <= CNT_W'(TABLE_SIZE)))
		else $error("priming count overrun");

	// the read stage always follows a lookup issue
	a_read_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> $past(issue))
		else $error("read stage without issue");

endmodule

// ===== test/tb_shuffled_lehmer_uniform_rng_top.sv =====
// Testbench for shuffled_lehmer_uniform_rng_top: directed and random draw requests
// checked against an in-bench Lehmer/shuffle-table predictor. Depends on slu_pkg.
`timescale 1ns / 1ps

module tb_shuffled_lehmer_uniform_rng_top;
	import slu_pkg::*;

	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 188;
	localparam int SETTLE_CYC   = 8;
	localparam int HOLD_CYC     = 300;

	typedef enum logic {ROW_DRAW, ROW_SEED} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [WORD_W-1:0] value;  // seed, or request bit in [0]
		logic              chk;
		logic [WORD_W-1:0] want;
	} dir_row_t;

	localparam dir_row_t DIRECTED [25] = '{
		'{ROW_DRAW, 31'd1,          1'b0, 31'd0},
		'{ROW_DRAW, 31'd0,          1'b0, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b0, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b0, 31'd0},
		'{ROW_SEED, 31'd1,          1'b0, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b0, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b0, 31'd0},
		'{ROW_SEED, 31'h7FFFFFFE,   1'b0, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b0, 31'd0},
		'{ROW_DRAW, 31'd0,          1'b0, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b0, 31'd0},
		'{ROW_SEED, 31'd0,          1'b0, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b1, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b1, 31'd0},
		'{ROW_DRAW, 31'd0,          1'b0, 31'd0},
		'{ROW_SEED, 31'h7FFFFFFF,   1'b0, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b1, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b1, 31'd0},
		'{ROW_SEED, 31'h2AAAAAAA,   1'b0, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b0, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b0, 31'd0},
		'{ROW_SEED, 31'h55555555,   1'b0, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b0, 31'd0},
		'{ROW_DRAW, 31'd1,          1'b0, 31'd0},
		'{ROW_DRAW, 31'd0,          1'b0, 31'd0}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [0] draw_request
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // [30:0] uniform_deviate
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [WORD_W-1:0]      cfg_data = '0;  // seed_value

	// predictor state
	logic [WORD_W-1:0] gen_x = 31'd1;
	logic [WORD_W-1:0] held_y = '0;
	logic [WORD_W-1:0] shuffle_tbl [TABLE_SIZE];
	logic              tbl_primed = 1'b0;

	logic [WORD_W-1:0] deviate_q [$];
	logic [WORD_W-1:0] want_dev;
	int                mismatch_count = 0;
	bit                tx_idle_on = 1'b1;
	bit                rx_idle_on = 1'b1;
	int                rx_hold_len = 0;

	shuffled_lehmer_uniform_rng_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [WORD_W-1:0] lehmer_advance();
		longint unsigned prod;
		prod = 64'(MULTIPLIER) * 64'(gen_x);
		gen_x = WORD_W'(prod % 64'(MODULUS));
		return gen_x;
	endfunction

	function automatic logic [WORD_W-1:0] draw_deviate();
		logic [IDX_W-1:0] slot;
		if (!tbl_primed) begin
			for (int i = 0; i < TABLE_SIZE; i++)
				shuffle_tbl[i] = lehmer_advance();
			held_y = lehmer_advance();
			tbl_primed = 1'b1;
		end
		slot = IDX_W'(held_y % TABLE_SIZE);
		held_y = shuffle_tbl[slot];
		shuffle_tbl[slot] = lehmer_advance();
		return held_y;
	endfunction

	task automatic report_mismatch(input string what, input logic [OUT_TDATA_W-1:0] got,
			input logic [OUT_TDATA_W-1:0] want);
		mismatch_count++;
		$display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (deviate_q.size() != 0);
	endtask

	task automatic write_seed(input logic [WORD_W-1:0] seed);
		wait_drained();
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= seed;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gen_x = seed;
		tbl_primed = 1'b0;
	endtask

	task automatic send_request(input logic req, input logic chk, input logic [WORD_W-1:0] want);
		logic [WORD_W-1:0] y;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, req};
		do @(posedge clk); while (!s_tready);
		if (req) begin
			y = draw_deviate();
			deviate_q.push_back(chk ? want : y);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (deviate_q.size() == 0) begin
				report_mismatch("unexpected transaction", m_tdata, '0);
			end else begin
				want_dev = deviate_q.pop_front();
				if (m_tdata !== {{(OUT_TDATA_W-WORD_W){1'b0}}, want_dev})
					report_mismatch("uniform_deviate", m_tdata,
						{{(OUT_TDATA_W-WORD_W){1'b0}}, want_dev});
			end
		end
	end

	// result sink with random backpressure and one long hold-off
	initial begin
		int hold;
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_hold_len != 0) begin
				hold = rx_hold_len;
				rx_hold_len = 0;
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [WORD_W-1:0] seed;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_SEED)
				write_seed(DIRECTED[i].value);
			else
				send_request(DIRECTED[i].value[0], DIRECTED[i].chk, DIRECTED[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 11))
				0:       seed = 31'd1;
				1:       seed = 31'h7FFFFFFE;
				2:       seed = 31'd0;
				3:       seed = 31'h7FFFFFFF;
				default: seed = WORD_W'($urandom());
			endcase
			write_seed(seed);
			if (ph == PHASES - 1) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 32 == 0 && ph != PHASES - 1) begin
					tx_idle_on = ($urandom_range(0, 2) != 0);
					rx_idle_on = ($urandom_range(0, 2) != 0);
				end
				// sink holds off while requests keep coming
				if (ph == 1 && n == 40) begin
					rx_hold_len = HOLD_CYC;
					tx_idle_on = 1'b0;
				end
				if (ph == 2 && n == 100)
					wait_drained();
				send_request($urandom_range(0, 9) != 0, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && deviate_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
